// File: rtl/tlc_pkg.sv
// shared types, widths and codes for the trajectory lerp compressor
// depends on nothing
`timescale 1ns / 1ps

package tlc_pkg;

    localparam int WINDOW_DEPTH = 16;
    localparam int FRAC_BITS    = 16;

    localparam int COORD_W = 24;
    localparam int TIME_W  = 32;
    localparam int FRAC_W  = FRAC_BITS + 1;
    localparam int DELTA_W = COORD_W + 1;
    localparam int PROD_W  = DELTA_W + FRAC_W + 1;
    localparam int ERR_W   = PROD_W - FRAC_BITS + 2;
    localparam int SQ_W    = 2 * ERR_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int IDX_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);

    localparam int PTH_W  = 32;
    localparam int ETH_W  = 23;
    localparam int MAXW_W = 5;
    localparam int CIDX_W = 2;

    localparam logic [CIDX_W-1:0] REG_POS_TH  = 2'd0;
    localparam logic [CIDX_W-1:0] REG_ELEV_TH = 2'd1;
    localparam logic [CIDX_W-1:0] REG_MAX_WIN = 2'd2;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] elev;
        logic [TIME_W-1:0]         t;
    } point_t;

    localparam int POINT_W = $bits(point_t);

endpackage

// File: rtl/tlc_ram.sv
// generic single-port synchronous ram with registered read
// depends on nothing
`timescale 1ns / 1ps

module tlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                        wr_data,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wr_data;
        end
        if (re)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/tlc_div.sv
// radix-2 restoring divider for the time fraction, one quotient bit a cycle
// depends on tlc_pkg
`timescale 1ns / 1ps

module tlc_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tlc_pkg::TIME_W-1:0]    dividend,
    input  logic [tlc_pkg::TIME_W-1:0]    divisor,
    output logic                          done,
    output logic [tlc_pkg::FRAC_W-1:0]    quotient
);

    localparam int REM_W = tlc_pkg::TIME_W + 1;
    localparam int STEP_W = $clog2(tlc_pkg::FRAC_W + 1);

    logic [REM_W-1:0]            rem_reg, rem_next;
    logic [tlc_pkg::FRAC_W-1:0]  quo_reg, quo_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic                        qbit;
    logic [REM_W-1:0]            rem_sub;

    always_comb
    begin
        qbit      = (rem_reg >= {1'b0, divisor});
        rem_sub   = qbit ? (rem_reg - {1'b0, divisor}) : rem_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = {1'b0, dividend};
            quo_next  = '0;
            step_next = STEP_W'(tlc_pkg::FRAC_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = {rem_sub[REM_W-2:0], 1'b0};
            quo_next  = {quo_reg[tlc_pkg::FRAC_W-2:0], qbit};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/trajectory_lerp_compressor.sv
// top level of the trajectory lerp compressor: sequencer, lerp datapath, output register
// depends on tlc_pkg, tlc_ram, tlc_div
`timescale 1ns / 1ps

// channel  | handshake             | payload
// in       | in_valid / in_stall   | opcode, pos_x, pos_y, pos_z, elevation, time_ms
// out      | out_valid / out_stall | out_x, out_y, out_z, out_elevation, out_time_ms
// cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// a sample with an empty window or a span that is not positive goes through accept and
// window write; each buffered point it checks goes through read, divider start, the
// division for the fraction, then multiply, error, square and compare
// a flush or a forced emission adds read, read wait and output load; reset clears the
// anchor, the fill count, the sequencer and the output valid flag, and loads the
// default configuration; in_stall is high while an item is worked on; the emit step
// holds while the output register is still full and stalled

module trajectory_lerp_compressor (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 opcode,
    input  logic signed [tlc_pkg::COORD_W-1:0]   pos_x,
    input  logic signed [tlc_pkg::COORD_W-1:0]   pos_y,
    input  logic signed [tlc_pkg::COORD_W-1:0]   pos_z,
    input  logic signed [tlc_pkg::COORD_W-1:0]   elevation,
    input  logic [tlc_pkg::TIME_W-1:0]           time_ms,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [tlc_pkg::COORD_W-1:0]   out_x,
    output logic signed [tlc_pkg::COORD_W-1:0]   out_y,
    output logic signed [tlc_pkg::COORD_W-1:0]   out_z,
    output logic signed [tlc_pkg::COORD_W-1:0]   out_elevation,
    output logic [tlc_pkg::TIME_W-1:0]           out_time_ms,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tlc_pkg::CIDX_W-1:0]           cfg_index,
    input  logic [tlc_pkg::PTH_W-1:0]            cfg_data
);

    localparam int CNT_W   = tlc_pkg::CNT_W;
    localparam int IDX_W   = tlc_pkg::IDX_W;
    localparam int ERR_W   = tlc_pkg::ERR_W;
    localparam int DELTA_W = tlc_pkg::DELTA_W;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_RD    = 12'b000000000010,
        S_DIVGO = 12'b000000000100,
        S_DIVW  = 12'b000000001000,
        S_MUL   = 12'b000000010000,
        S_ERR   = 12'b000000100000,
        S_SQ    = 12'b000001000000,
        S_CMP   = 12'b000010000000,
        S_FRD   = 12'b000100000000,
        S_FWAIT = 12'b001000000000,
        S_EMIT  = 12'b010000000000,
        S_WR    = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [tlc_pkg::PTH_W-1:0]  pos_th_reg;
    logic [tlc_pkg::ETH_W-1:0]  elev_th_reg;
    logic [tlc_pkg::MAXW_W-1:0] max_win_reg;

    // anchor and window bookkeeping
    tlc_pkg::point_t anchor_reg, anchor_next;
    logic            anchor_valid_reg, anchor_valid_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;

    // item being worked on
    tlc_pkg::point_t sample_reg;
    logic [tlc_pkg::TIME_W-1:0] range_reg;
    logic then_write_reg, then_write_next;
    logic from_sample_reg, from_sample_next;

    // lerp datapath registers
    logic signed [tlc_pkg::PROD_W-1:0] prod_reg [4];
    logic signed [ERR_W-1:0]           err_reg [4];
    logic [tlc_pkg::SQ_W-1:0]          sq_reg [3];
    logic [ERR_W-1:0]                  eabs_reg;

    // output register
    tlc_pkg::point_t out_reg;
    logic            out_valid_reg, out_valid_next;

    // memory and divider
    logic                         ram_we, ram_re;
    logic [IDX_W-1:0]             ram_addr;
    logic [tlc_pkg::POINT_W-1:0]  ram_rd;
    tlc_pkg::point_t              entry;
    logic                         div_start, div_done;
    logic [tlc_pkg::TIME_W-1:0]   div_num;
    logic [tlc_pkg::FRAC_W-1:0]   frac;

    logic                         in_xfer;
    logic                         out_free;
    logic [CNT_W-1:0]             limit;
    logic [tlc_pkg::TIME_W:0]     rng_in;
    logic                         rng_pos;
    logic [tlc_pkg::TIME_W:0]     diff_raw;
    logic                         entry_ok;
    logic [tlc_pkg::SUM_W-1:0]    dsq;
    tlc_pkg::point_t              in_point;

    // anchor plus round-half-up of the scaled delta, minus the buffered point
    function automatic logic signed [ERR_W-1:0] lerp_err(
        input logic signed [tlc_pkg::COORD_W-1:0] a,
        input logic signed [tlc_pkg::PROD_W-1:0]  p,
        input logic signed [tlc_pkg::COORD_W-1:0] mid
    );
        logic signed [tlc_pkg::PROD_W-1:0] q;
        logic signed [tlc_pkg::PROD_W-1:0] sh;
        q  = p + tlc_pkg::PROD_W'(1 << (tlc_pkg::FRAC_BITS - 1));
        sh = q >>> tlc_pkg::FRAC_BITS;
        return ERR_W'(sh) + ERR_W'(a) - ERR_W'(mid);
    endfunction

    assign entry    = tlc_pkg::point_t'(ram_rd);
    assign in_xfer  = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    assign in_point = '{x: pos_x, y: pos_y, z: pos_z, elev: elevation, t: time_ms};

    // window limit saturated to the memory depth
    assign limit = ({27'd0, max_win_reg} >= 32'(tlc_pkg::WINDOW_DEPTH))
                 ? CNT_W'(tlc_pkg::WINDOW_DEPTH) : CNT_W'(max_win_reg);

    // time span from the anchor; a span that is not positive passes every point
    assign rng_in  = {1'b0, time_ms} - {1'b0, anchor_reg.t};
    assign rng_pos = !rng_in[tlc_pkg::TIME_W] && (rng_in != '0);

    // entry time offset clamped into [0, span]
    assign diff_raw = {1'b0, entry.t} - {1'b0, anchor_reg.t};
    always_comb
    begin
        if (diff_raw[tlc_pkg::TIME_W])
        begin
            div_num = '0;
        end
        else if (diff_raw[tlc_pkg::TIME_W-1:0] > range_reg)
        begin
            div_num = range_reg;
        end
        else
        begin
            div_num = diff_raw[tlc_pkg::TIME_W-1:0];
        end
    end

    assign dsq = tlc_pkg::SUM_W'(sq_reg[0]) + tlc_pkg::SUM_W'(sq_reg[1])
               + tlc_pkg::SUM_W'(sq_reg[2]);
    assign entry_ok = (dsq < tlc_pkg::SUM_W'(pos_th_reg))
                   && (eabs_reg < ERR_W'(elev_th_reg));

    tlc_ram #(
        .WIDTH(tlc_pkg::POINT_W),
        .DEPTH(tlc_pkg::WINDOW_DEPTH)
    ) u_window (
        .clk     (clk),
        .we      (ram_we),
        .re      (ram_re),
        .addr    (ram_addr),
        .wr_data (sample_reg),
        .rd_data (ram_rd)
    );

    tlc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (range_reg),
        .done     (div_done),
        .quotient (frac)
    );

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        anchor_next       = anchor_reg;
        anchor_valid_next = anchor_valid_reg;
        count_next        = count_reg;
        idx_next          = idx_reg;
        then_write_next   = then_write_reg;
        from_sample_next  = from_sample_reg;
        out_valid_next    = out_valid_reg && out_stall;
        ram_we            = 1'b0;
        ram_re            = 1'b0;
        ram_addr          = idx_reg[IDX_W-1:0];
        div_start         = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    from_sample_next = 1'b0;
                    idx_next         = '0;
                    if (opcode == tlc_pkg::OP_FLUSH)
                    begin
                        then_write_next = 1'b0;
                        if (count_reg != '0)
                        begin
                            state_next = S_FRD;
                        end
                    end
                    else if (!anchor_valid_reg)
                    begin
                        // first sample goes straight out
                        from_sample_next = 1'b1;
                        then_write_next  = 1'b0;
                        state_next       = S_EMIT;
                    end
                    else if (count_reg >= limit)
                    begin
                        then_write_next = 1'b1;
                        state_next = (count_reg != '0) ? S_FRD : S_WR;
                    end
                    else if (count_reg == '0 || !rng_pos)
                    begin
                        state_next = S_WR;
                    end
                    else
                    begin
                        then_write_next = 1'b1;
                        state_next      = S_RD;
                    end
                end
            end
            S_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_DIVGO;
            end
            S_DIVGO:
            begin
                div_start  = 1'b1;
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (div_done)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_ERR;
            end
            S_ERR:
            begin
                state_next = S_SQ;
            end
            S_SQ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (!entry_ok)
                begin
                    state_next = S_FRD;
                end
                else if (idx_reg + 1'b1 == count_reg)
                begin
                    state_next = S_WR;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_FRD:
            begin
                ram_re     = 1'b1;
                ram_addr   = IDX_W'(count_reg - 1'b1);
                state_next = S_FWAIT;
            end
            S_FWAIT:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    anchor_valid_next = 1'b1;
                    anchor_next       = from_sample_reg ? sample_reg : entry;
                    if (!from_sample_reg)
                    begin
                        count_next = '0;
                    end
                    state_next = then_write_reg ? S_WR : S_IDLE;
                end
            end
            S_WR:
            begin
                ram_we     = 1'b1;
                ram_addr   = count_reg[IDX_W-1:0];
                count_next = count_reg + 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            anchor_reg       <= '0;
            anchor_valid_reg <= 1'b0;
            count_reg        <= '0;
            idx_reg          <= '0;
            then_write_reg   <= 1'b0;
            from_sample_reg  <= 1'b0;
            out_valid_reg    <= 1'b0;
            pos_th_reg       <= tlc_pkg::PTH_W'(16384);
            elev_th_reg      <= tlc_pkg::ETH_W'(128);
            max_win_reg      <= tlc_pkg::MAXW_W'(10);
        end
        else
        begin
            state_reg        <= state_next;
            anchor_reg       <= anchor_next;
            anchor_valid_reg <= anchor_valid_next;
            count_reg        <= count_next;
            idx_reg          <= idx_next;
            then_write_reg   <= then_write_next;
            from_sample_reg  <= from_sample_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    tlc_pkg::REG_POS_TH:  pos_th_reg  <= cfg_data;
                    tlc_pkg::REG_ELEV_TH: elev_th_reg <= cfg_data[tlc_pkg::ETH_W-1:0];
                    tlc_pkg::REG_MAX_WIN: max_win_reg <= cfg_data[tlc_pkg::MAXW_W-1:0];
                    default:              ;
                endcase
            end
        end
    end

    // lerp datapath: sample capture, product, rounded error, squares, output load
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            sample_reg <= in_point;
            range_reg  <= rng_in[tlc_pkg::TIME_W-1:0];
        end
        if (state_reg == S_MUL)
        begin
            prod_reg[0] <= (DELTA_W'(sample_reg.x) - DELTA_W'(anchor_reg.x))
                           * $signed({1'b0, frac});
            prod_reg[1] <= (DELTA_W'(sample_reg.y) - DELTA_W'(anchor_reg.y))
                           * $signed({1'b0, frac});
            prod_reg[2] <= (DELTA_W'(sample_reg.z) - DELTA_W'(anchor_reg.z))
                           * $signed({1'b0, frac});
            prod_reg[3] <= (DELTA_W'(sample_reg.elev) - DELTA_W'(anchor_reg.elev))
                           * $signed({1'b0, frac});
        end
        if (state_reg == S_ERR)
        begin
            err_reg[0] <= lerp_err(anchor_reg.x, prod_reg[0], entry.x);
            err_reg[1] <= lerp_err(anchor_reg.y, prod_reg[1], entry.y);
            err_reg[2] <= lerp_err(anchor_reg.z, prod_reg[2], entry.z);
            err_reg[3] <= lerp_err(anchor_reg.elev, prod_reg[3], entry.elev);
        end
        if (state_reg == S_SQ)
        begin
            sq_reg[0] <= tlc_pkg::SQ_W'(err_reg[0]) * tlc_pkg::SQ_W'(err_reg[0]);
            sq_reg[1] <= tlc_pkg::SQ_W'(err_reg[1]) * tlc_pkg::SQ_W'(err_reg[1]);
            sq_reg[2] <= tlc_pkg::SQ_W'(err_reg[2]) * tlc_pkg::SQ_W'(err_reg[2]);
            eabs_reg  <= err_reg[3][ERR_W-1] ? ERR_W'(-err_reg[3]) : ERR_W'(err_reg[3]);
        end
        if (state_reg == S_EMIT && out_free)
        begin
            out_reg <= from_sample_reg ? sample_reg : entry;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_x         = out_reg.x;
    assign out_y         = out_reg.y;
    assign out_z         = out_reg.z;
    assign out_elevation = out_reg.elev;
    assign out_time_ms   = out_reg.t;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(tlc_pkg::WINDOW_DEPTH))
        else $error("window fill count beyond depth");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIVW)
        else $error("divider finished outside its wait step");

    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> count_reg < CNT_W'(tlc_pkg::WINDOW_DEPTH))
        else $error("window write with no room");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_valid_reg && out_stall) |=> state_reg == S_EMIT)
        else $error("emit step left with output register full");
`endif

endmodule

// File: sim/tb_trajectory_lerp_compressor.sv
// self-checking testbench for the trajectory lerp compressor
// depends on tlc_pkg and the trajectory_lerp_compressor rtl
`timescale 1ns / 1ps

module tb_trajectory_lerp_compressor;

    localparam int COORD_W      = tlc_pkg::COORD_W;
    localparam int TIME_W       = tlc_pkg::TIME_W;
    localparam int CIDX_W       = tlc_pkg::CIDX_W;
    localparam int PTH_W        = tlc_pkg::PTH_W;
    localparam int ETH_W        = tlc_pkg::ETH_W;
    localparam int MAXW_W       = tlc_pkg::MAXW_W;
    localparam int WINDOW_DEPTH = tlc_pkg::WINDOW_DEPTH;
    localparam int FRAC_BITS    = tlc_pkg::FRAC_BITS;

    // one input transfer as the driver presents it
    typedef struct {
        logic                      op;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] e;
        logic [TIME_W-1:0]         t;
    } sample_t;

    localparam int DRAIN_CYCLES = 600;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic opcode;
    logic signed [COORD_W-1:0] pos_x, pos_y, pos_z, elevation;
    logic [TIME_W-1:0] time_ms;
    logic out_valid;
    logic out_stall;
    logic signed [COORD_W-1:0] out_x, out_y, out_z, out_elevation;
    logic [TIME_W-1:0] out_time_ms;
    logic cfg_valid;
    logic cfg_ready;
    logic [CIDX_W-1:0] cfg_index;
    logic [PTH_W-1:0] cfg_data;

    trajectory_lerp_compressor dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .elevation(elevation),
        .time_ms(time_ms),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_x(out_x), .out_y(out_y), .out_z(out_z),
        .out_elevation(out_elevation), .out_time_ms(out_time_ms),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // ---------------------------------------------------------------
    // predictor state: configuration copy, anchor and window
    // ---------------------------------------------------------------
    logic [PTH_W-1:0]  pos_limit_sq;
    logic [ETH_W-1:0]  elev_limit;
    logic [MAXW_W-1:0] window_limit;

    logic              have_anchor;
    tlc_pkg::point_t   anchor;
    int                fill;
    tlc_pkg::point_t   window_pts[WINDOW_DEPTH];

    tlc_pkg::point_t emitted_q[$];  // points the block still owes us
    sample_t pending_q[$];          // transfers waiting to be driven
    sample_t cur;

    int errors;
    int samples_sent;
    int flushes_sent;
    int points_seen;
    int cfg_writes;
    bit quiet;                  // long stretch with no idling on either side

    // error of one coordinate against the lerp from a to b at frac
    function automatic longint lerp_miss(longint a, longint b, longint frac, longint mid);
        longint p;
        p = (b - a) * frac;
        // floor of (p + half) / 2^FRAC_BITS, round half up
        return a + ((p + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS) - mid;
    endfunction

    // does window entry i stay on the line from the anchor to s
    function automatic bit stays_on_line(int i, sample_t s);
        longint span, diff, frac, ex, ey, ez, ee;
        longint unsigned dsq;
        span = longint'(s.t) - longint'(anchor.t);
        if (span <= 0)
            return 1'b1;
        diff = longint'(window_pts[i].t) - longint'(anchor.t);
        if (diff < 0)
            diff = 0;
        if (diff > span)
            diff = span;
        frac = (diff << FRAC_BITS) / span;
        ex = lerp_miss(anchor.x, s.x, frac, window_pts[i].x);
        ey = lerp_miss(anchor.y, s.y, frac, window_pts[i].y);
        ez = lerp_miss(anchor.z, s.z, frac, window_pts[i].z);
        ee = lerp_miss(anchor.elev, s.e, frac, window_pts[i].elev);
        dsq = ex * ex + ey * ey + ez * ez;
        if (ee < 0)
            ee = -ee;
        return (dsq < longint'(pos_limit_sq)) && (ee < longint'(elev_limit));
    endfunction

    function automatic void emit_point(tlc_pkg::point_t p);
        have_anchor = 1'b1;
        anchor = p;
        emitted_q.insert(emitted_q.size(), p);
    endfunction

    function automatic void flush_newest();
        if (fill > 0)
        begin
            emit_point(window_pts[fill-1]);
            fill = 0;
        end
    endfunction

    // advance the compressor state by one accepted transfer
    function automatic void compress_sample(sample_t s);
        tlc_pkg::point_t p;
        int limit;
        bit keep;
        p.x = s.x;
        p.y = s.y;
        p.z = s.z;
        p.elev = s.e;
        p.t = s.t;
        if (s.op == tlc_pkg::OP_FLUSH)
        begin
            flush_newest();
            return;
        end
        if (!have_anchor)
        begin
            emit_point(p);
            return;
        end
        limit = (window_limit < WINDOW_DEPTH) ? window_limit : WINDOW_DEPTH;
        keep = fill < limit;
        for (int i = 0; keep && i < fill; i++)
            if (!stays_on_line(i, s))
                keep = 1'b0;
        if (!keep)
            flush_newest();
        if (fill < WINDOW_DEPTH)
        begin
            window_pts[fill] = p;
            fill++;
        end
    endfunction

    // ---------------------------------------------------------------
    // driver: presents queued transfers, idles at random
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            opcode <= tlc_pkg::OP_SAMPLE;
            pos_x <= '0;
            pos_y <= '0;
            pos_z <= '0;
            elevation <= '0;
            time_ms <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                compress_sample(cur);
                if (cur.op == tlc_pkg::OP_FLUSH)
                    flushes_sent++;
                else
                    samples_sent++;
            end
            // a held payload stays put until its transfer happens
            if (!in_valid || !in_stall)
            begin
                if (pending_q.size() > 0 && (quiet || $urandom_range(99) >= 26))
                begin
                    cur = pending_q.pop_front();
                    in_valid <= 1'b1;
                    opcode <= cur.op;
                    pos_x <= cur.x;
                    pos_y <= cur.y;
                    pos_z <= cur.z;
                    elevation <= cur.e;
                    time_ms <= cur.t;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: random stall, compare each emitted point with the oldest owed
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        tlc_pkg::point_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                points_seen++;
                if (emitted_q.size() == 0)
                begin
                    $display("%0t: expected no point got x=%0d t=%0d",
                             $time, out_x, out_time_ms);
                    errors++;
                end
                else
                begin
                    want = emitted_q.pop_front();
                    if (out_x !== want.x)
                    begin
                        $display("%0t: out_x expected %0d got %0d", $time, want.x, out_x);
                        errors++;
                    end
                    if (out_y !== want.y)
                    begin
                        $display("%0t: out_y expected %0d got %0d", $time, want.y, out_y);
                        errors++;
                    end
                    if (out_z !== want.z)
                    begin
                        $display("%0t: out_z expected %0d got %0d", $time, want.z, out_z);
                        errors++;
                    end
                    if (out_elevation !== want.elev)
                    begin
                        $display("%0t: out_elevation expected %0d got %0d",
                                 $time, want.elev, out_elevation);
                        errors++;
                    end
                    if (out_time_ms !== want.t)
                    begin
                        $display("%0t: out_time_ms expected %0d got %0d",
                                 $time, want.t, out_time_ms);
                        errors++;
                    end
                end
            end
            out_stall <= !quiet && ($urandom_range(99) < 26);
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    function automatic sample_t make_sample(logic op, int x, int y, int z, int e,
                                            logic [TIME_W-1:0] t);
        sample_t s;
        s.op = op;
        s.x = COORD_W'(x);
        s.y = COORD_W'(y);
        s.z = COORD_W'(z);
        s.e = COORD_W'(e);
        s.t = t;
        return s;
    endfunction

    function automatic void queue_item(sample_t s);
        pending_q.insert(pending_q.size(), s);
    endfunction

    function automatic int rand_coord();
        return int'($signed(24'($urandom())));
    endfunction

    // a track moving along a line, with occasional bends and a random amount of jitter, then maybe a flush
    logic [TIME_W-1:0] clock_ms;

    function automatic int push_track();
        int n, vx, vy, vz, ve, px, py, pz, pe, jit, dt, bend;
        n = $urandom_range(3, 24);
        px = $urandom_range(0, 2_000_000) - 1_000_000;
        py = $urandom_range(0, 2_000_000) - 1_000_000;
        pz = $urandom_range(0, 2_000_000) - 1_000_000;
        pe = $urandom_range(0, 2_000_000) - 1_000_000;
        vx = $urandom_range(0, 400) - 200;
        vy = $urandom_range(0, 400) - 200;
        vz = $urandom_range(0, 100) - 50;
        ve = $urandom_range(0, 100) - 50;
        case ($urandom_range(3))
            0: jit = 0;
            1: jit = 40;
            2: jit = 150;
            default: jit = 2000;
        endcase
        for (int i = 0; i < n; i++)
        begin
            dt = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 60);
            clock_ms += dt;
            bend = $urandom_range(15) == 0;
            if (bend)
                vx = -vx + $urandom_range(0, 100) - 50;
            px += vx * dt;
            py += vy * dt;
            pz += vz * dt;
            pe += ve * dt;
            queue_item(make_sample(tlc_pkg::OP_SAMPLE,
                px + $urandom_range(0, 2 * jit) - jit,
                py + $urandom_range(0, 2 * jit) - jit,
                pz + $urandom_range(0, 2 * jit) - jit,
                pe + $urandom_range(0, 2 * jit) - jit, clock_ms));
        end
        if ($urandom_range(2) != 0)
        begin
            queue_item(make_sample(tlc_pkg::OP_FLUSH, rand_coord(), rand_coord(),
                                   rand_coord(), rand_coord(), $urandom()));
            n++;
        end
        return n;
    endfunction

    // noise and broken sequences: full range fields, time jumps either way
    function automatic void push_noise();
        queue_item(make_sample($urandom_range(3) == 0, rand_coord(),
                               rand_coord(), rand_coord(), rand_coord(),
                               $urandom()));
    endfunction

    function automatic void push_random(int count);
        int made;
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(9) < 8)
                made += push_track();
            else
            begin
                push_noise();
                made++;
            end
        end
    endfunction

    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [PTH_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            tlc_pkg::REG_POS_TH:  pos_limit_sq = value;
            tlc_pkg::REG_ELEV_TH: elev_limit = value[ETH_W-1:0];
            tlc_pkg::REG_MAX_WIN: window_limit = value[MAXW_W-1:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic configure(logic [PTH_W-1:0] pth, logic [ETH_W-1:0] eth,
                             logic [MAXW_W-1:0] maxw);
        write_reg(tlc_pkg::REG_POS_TH, pth);
        write_reg(tlc_pkg::REG_ELEV_TH, PTH_W'(eth));
        write_reg(tlc_pkg::REG_MAX_WIN, PTH_W'(maxw));
    endtask

    // all transfers in, all points out, then let a silent item finish
    task automatic wait_idle();
        @(negedge clk);
        while (pending_q.size() > 0 || in_valid || emitted_q.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial
    begin
        errors = 0;
        samples_sent = 0;
        flushes_sent = 0;
        points_seen = 0;
        cfg_writes = 0;
        quiet = 1'b0;
        clock_ms = 0;
        fill = 0;
        have_anchor = 1'b0;
        anchor = '0;
        pos_limit_sq = 32'd16384;
        elev_limit = 23'd128;
        window_limit = 5'd10;
        cfg_valid = 1'b0;
        cfg_index = tlc_pkg::REG_POS_TH;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: flush before any sample, extremes, zero span, time going back
        queue_item(make_sample(tlc_pkg::OP_FLUSH, 0, 0, 0, 0, 0));
        queue_item(make_sample(tlc_pkg::OP_SAMPLE, 8388607, 8388607, 8388607, 8388607, 0));
        queue_item(make_sample(tlc_pkg::OP_FLUSH, 0, 0, 0, 0, 0));
        queue_item(make_sample(tlc_pkg::OP_SAMPLE, -8388608, -8388608, -8388608,
                               -8388608, 32'hFFFF_FFFF));
        queue_item(make_sample(tlc_pkg::OP_SAMPLE, 8388607, -8388608, 8388607,
                               -8388608, 32'hFFFF_FFFF));
        queue_item(make_sample(tlc_pkg::OP_SAMPLE, 0, 0, 0, 0, 32'hFFFF_FFFF));
        queue_item(make_sample(tlc_pkg::OP_SAMPLE, 100, 100, 100, 100, 5));
        queue_item(make_sample(tlc_pkg::OP_SAMPLE, 200, 200, 200, 200, 10));
        queue_item(make_sample(tlc_pkg::OP_FLUSH, -1, -1, -1, -1, 32'hFFFF_FFFF));
        queue_item(make_sample(tlc_pkg::OP_FLUSH, 0, 0, 0, 0, 0));
        // straight line long enough to hit the window limit
        for (int i = 1; i <= 12; i++)
            queue_item(make_sample(tlc_pkg::OP_SAMPLE, 256 * i, -256 * i, 0, 64 * i,
                                   32'd1000 + 10 * i));
        queue_item(make_sample(tlc_pkg::OP_FLUSH, 0, 0, 0, 0, 0));
        clock_ms = 32'd2000;
        wait_idle();

        // loose limits, largest window
        configure(32'hFFFF_FFFF, 23'h7F_FFFF, 5'd16);
        push_random(450);
        wait_idle();

        // tightest limits, a window of one point
        configure(32'd0, 23'd0, 5'd1);
        push_random(300);
        wait_idle();

        // defaults, with a long quiet stretch and a pause until the block drains
        configure(32'd16384, 23'd128, 5'd10);
        quiet = 1'b1;
        push_random(250);
        wait_idle();
        quiet = 1'b0;
        push_random(250);
        wait_idle();

        // medium limits
        configure(32'd1_000_000, 23'd2000, 5'd5);
        push_random(350);
        wait_idle();

        configure(32'd4096, 23'd64, 5'd16);
        push_random(400);
        wait_idle();

        $display("covered %0d samples and %0d flushes, %0d points emitted, %0d register writes",
                 samples_sent, flushes_sent, points_seen, cfg_writes);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // hard stop if the block hangs
    initial
    begin
        #200_000_000;
        $display("timeout with %0d points still owed", emitted_q.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
